// ----- hw/rtl/ebb_pkg.sv -----
// ----------------------------------------------------------------------------
// Edge background blanking package
// Shared sizes, word types, codes and pixel mask functions of the blanker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ebb_pkg;

    localparam int MAX_COLUMNS = 2048;
    localparam int MAX_ROWS    = 32;
    localparam int PIX_W       = 32;
    localparam int IDX_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int ADDR_W      = $clog2(MAX_COLUMNS);
    localparam int CNT_W       = ($clog2(MAX_COLUMNS + 2) > IDX_W) ?
                                 $clog2(MAX_COLUMNS + 2) : IDX_W;
    localparam int ROW_CAP     = (MAX_ROWS < PIX_W) ? MAX_ROWS : PIX_W;
    localparam int STEP_N      = $clog2(PIX_W);

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_RUN  = 2'd1,
        ACT_READ = 2'd2
    } ebb_action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_INVERT = 2'd2,
        CFG_SWEEP  = 2'd3
    } ebb_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FWD,
        ST_BWD,
        ST_DONE
    } ebb_state_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] column_index;
        logic [PIX_W-1:0] column_pixels;
    } ebb_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] lit_pixels;
        logic             status;
    } ebb_out_t;

    typedef struct packed {
        logic [10:0] image_width;
        logic [5:0]  image_height;
        logic        invert_pixels;
        logic [3:0]  sweep_enable;
    } ebb_cfg_t;

    typedef struct packed {
        logic              white_re;
        logic [ADDR_W-1:0] white_raddr;
        logic              mark_re;
        logic [ADDR_W-1:0] mark_raddr;
        logic              mark_we;
        logic [ADDR_W-1:0] mark_waddr;
        logic [PIX_W-1:0]  mark_wdata;
    } ebb_mem_req_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ebb_eng_stat_t;

    function automatic logic [CNT_W-1:0] used_width(input logic [10:0] width);
        logic [CNT_W-1:0] wx;
        wx = CNT_W'(width);
        return (wx > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : wx;
    endfunction

    function automatic logic [PIX_W-1:0] height_mask(input logic [5:0] height);
        logic [PIX_W-1:0] m;
        for (int i = 0; i < PIX_W; i++)
        begin
            m[i] = (i < int'(height)) && (i < ROW_CAP);
        end
        return m;
    endfunction

    // A pixel passes when it is white and no 4-neighbour inside the image is black.
    function automatic logic [PIX_W-1:0] pass_mask(
        input logic [PIX_W-1:0] left_col,
        input logic [PIX_W-1:0] cen_col,
        input logic [PIX_W-1:0] right_col,
        input logic             left_ok,
        input logic             right_ok,
        input logic [PIX_W-1:0] hm
    );
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] blk;
        logic [PIX_W-1:0] near;
        col  = cen_col & hm;
        blk  = ~col & hm;
        near = (blk << 1) | (blk >> 1);
        if (left_ok)
        begin
            near = near | (~left_col & hm);
        end
        if (right_ok)
        begin
            near = near | (~right_col & hm);
        end
        return col & ~near & hm;
    endfunction

    // Run of passing pixels from row 0 upwards.
    function automatic logic [PIX_W-1:0] top_run(input logic [PIX_W-1:0] ok);
        logic [PIX_W-1:0] p;
        p = ok;
        for (int i = 0; i < STEP_N; i++)
        begin
            p = p & ((p << (1 << i)) | ~({PIX_W{1'b1}} << (1 << i)));
        end
        return p;
    endfunction

    // Run of passing pixels from the last row in use downwards.
    function automatic logic [PIX_W-1:0] bottom_run(
        input logic [PIX_W-1:0] ok,
        input logic [PIX_W-1:0] hm
    );
        logic [PIX_W-1:0] e;
        e = ok | ~hm;
        for (int i = 0; i < STEP_N; i++)
        begin
            e = e & ((e >> (1 << i)) | ~({PIX_W{1'b1}} >> (1 << i)));
        end
        return e & hm;
    endfunction

endpackage

// ----- hw/rtl/ebb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ebb_engine.sv -----
// ----------------------------------------------------------------------------
// Blanking sweep engine
// Clears the mark memory after reset and runs the forward and, if enabled,
// backward column passes of a blanking run over the white and mark memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebb_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  ebb_pkg::ebb_cfg_t            cfg,
    input  logic [ebb_pkg::PIX_W-1:0]    white_q,
    input  logic [ebb_pkg::PIX_W-1:0]    mark_q,
    output ebb_pkg::ebb_mem_req_t        req,
    output ebb_pkg::ebb_eng_stat_t       stat
);

    ebb_pkg::ebb_state_t             state_reg, state_next;
    logic [ebb_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [ebb_pkg::PIX_W-1:0]       alive_reg, alive_next;
    logic [ebb_pkg::PIX_W-1:0]       prv_reg, prv_next;
    logic [ebb_pkg::PIX_W-1:0]       cur_reg, cur_next;

    logic [ebb_pkg::CNT_W-1:0]       used_w;
    logic [ebb_pkg::PIX_W-1:0]       hmask;
    logic                            fwd;
    logic [ebb_pkg::CNT_W-1:0]       x;
    logic [ebb_pkg::CNT_W-1:0]       back_addr;
    logic [ebb_pkg::CNT_W-1:0]       mark_addr;
    logic [ebb_pkg::PIX_W-1:0]       left_col;
    logic [ebb_pkg::PIX_W-1:0]       right_col;
    logic                            left_ok;
    logic                            right_ok;
    logic [ebb_pkg::PIX_W-1:0]       ok;
    logic [ebb_pkg::PIX_W-1:0]       vert;
    logic [ebb_pkg::PIX_W-1:0]       alive_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ebb_pkg::ST_CLEAR;
            cnt_reg   <= '0;
            alive_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            alive_reg <= alive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prv_reg <= prv_next;
        cur_reg <= cur_next;
    end

    always_comb
    begin
        used_w    = ebb_pkg::used_width(cfg.image_width);
        hmask     = ebb_pkg::height_mask(cfg.image_height);
        fwd       = (state_reg == ebb_pkg::ST_FWD);
        x         = fwd ? (cnt_reg - ebb_pkg::CNT_W'(2))
                        : (used_w + ebb_pkg::CNT_W'(1) - cnt_reg);
        back_addr = used_w - cnt_reg - ebb_pkg::CNT_W'(1);
        mark_addr = used_w - cnt_reg;
        left_col  = fwd ? prv_reg : white_q;
        right_col = fwd ? white_q : prv_reg;
        left_ok   = (x != '0);
        right_ok  = ((x + ebb_pkg::CNT_W'(1)) < used_w);
        ok        = ebb_pkg::pass_mask(left_col, cur_reg, right_col, left_ok, right_ok,
                                       hmask);
        vert      = (cfg.sweep_enable[0] ? ebb_pkg::top_run(ok) : '0) |
                    (cfg.sweep_enable[1] ? ebb_pkg::bottom_run(ok, hmask) : '0);
        alive_new = alive_reg & ok;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        alive_next = alive_reg;
        prv_next   = prv_reg;
        cur_next   = cur_reg;
        req        = '0;
        stat       = '0;

        case (state_reg)
            ebb_pkg::ST_CLEAR:
            begin
                req.mark_we    = 1'b1;
                req.mark_waddr = cnt_reg[ebb_pkg::ADDR_W-1:0];
                req.mark_wdata = '0;
                if (cnt_reg == ebb_pkg::CNT_W'(ebb_pkg::MAX_COLUMNS - 1))
                begin
                    state_next = ebb_pkg::ST_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + ebb_pkg::CNT_W'(1);
                end
            end
            ebb_pkg::ST_IDLE:
            begin
                stat.idle = 1'b1;
                if (start)
                begin
                    state_next = ebb_pkg::ST_FWD;
                    cnt_next   = '0;
                    alive_next = hmask;
                end
            end
            ebb_pkg::ST_FWD:
            begin
                req.white_re    = (cnt_reg < ebb_pkg::CNT_W'(ebb_pkg::MAX_COLUMNS));
                req.white_raddr = cnt_reg[ebb_pkg::ADDR_W-1:0];
                prv_next        = cur_reg;
                cur_next        = white_q;
                if (cnt_reg >= ebb_pkg::CNT_W'(2))
                begin
                    req.mark_we    = 1'b1;
                    req.mark_waddr = x[ebb_pkg::ADDR_W-1:0];
                    if (x < used_w)
                    begin
                        req.mark_wdata = vert |
                                         (cfg.sweep_enable[2] ? alive_new : '0);
                        alive_next     = alive_new;
                    end
                    else
                    begin
                        req.mark_wdata = '0;
                    end
                end
                if (cnt_reg == ebb_pkg::CNT_W'(ebb_pkg::MAX_COLUMNS + 1))
                begin
                    cnt_next = '0;
                    if (cfg.sweep_enable[3] && (used_w != '0))
                    begin
                        state_next = ebb_pkg::ST_BWD;
                        alive_next = hmask;
                    end
                    else
                    begin
                        state_next = ebb_pkg::ST_DONE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + ebb_pkg::CNT_W'(1);
                end
            end
            ebb_pkg::ST_BWD:
            begin
                req.white_re    = (cnt_reg < used_w);
                req.white_raddr = back_addr[ebb_pkg::ADDR_W-1:0];
                req.mark_re     = (cnt_reg != '0) && (cnt_reg <= used_w);
                req.mark_raddr  = mark_addr[ebb_pkg::ADDR_W-1:0];
                prv_next        = cur_reg;
                cur_next        = white_q;
                if (cnt_reg >= ebb_pkg::CNT_W'(2))
                begin
                    req.mark_we    = 1'b1;
                    req.mark_waddr = x[ebb_pkg::ADDR_W-1:0];
                    req.mark_wdata = mark_q | alive_new;
                    alive_next     = alive_new;
                end
                if (cnt_reg == (used_w + ebb_pkg::CNT_W'(1)))
                begin
                    state_next = ebb_pkg::ST_DONE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + ebb_pkg::CNT_W'(1);
                end
            end
            ebb_pkg::ST_DONE:
            begin
                stat.done  = 1'b1;
                state_next = ebb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ebb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/edge_background_blanking_core.sv -----
// ----------------------------------------------------------------------------
// Edge background blanking core
// Monochrome column bitmap store with edge background blanking.
//
// The input channel carries one word per action: load a column, run the
// blanking, or read a column. Every accepted word gives exactly one result
// word on the output channel, in order. Configuration is written through a
// plain write port, by the user only while the block is idle; the block
// itself does not enforce this. A load or read result passes through the
// pending stage and the output register after acceptance. One load or read
// word can be accepted every cycle as long as results are taken.
// A run occupies the engine for a forward pass over all MAX_COLUMNS columns
// of the column memory, then a backward pass over the image columns when
// the right sweep is enabled and the width is not zero, then the done state;
// its result follows the end of the run and no word is accepted meanwhile.
// After reset the mark memory is cleared, one column a cycle, over all its
// columns with in_ready low; configuration writes are taken meanwhile.
// When the receiver stalls, one result is held at the output and one in a
// pending stage; further input is held off until space frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edge_background_blanking_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ebb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ebb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  ebb_pkg::ebb_in_t                 in_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output ebb_pkg::ebb_out_t                out_word
);

    logic [10:0]                   width_reg;
    logic [5:0]                    height_reg;
    logic                          invert_reg;
    logic [3:0]                    sweep_reg;
    ebb_pkg::ebb_cfg_t             cfg;

    logic                          pend_valid_reg, pend_valid_next;
    logic                          pend_read_reg, pend_read_next;
    logic                          pend_status_reg, pend_status_next;
    logic                          out_valid_reg, out_valid_next;
    ebb_pkg::ebb_out_t             out_word_reg, out_word_next;

    logic                          accept;
    logic                          act_load;
    logic                          act_read;
    logic                          act_run;
    logic                          in_range;
    logic                          out_free;
    logic                          pend_move;
    logic [ebb_pkg::CNT_W-1:0]     used_w;
    logic [ebb_pkg::PIX_W-1:0]     hmask;
    logic [ebb_pkg::ADDR_W-1:0]    idx_addr;
    logic [ebb_pkg::PIX_W-1:0]     load_data;
    logic                          white_we;
    logic                          white_re;
    logic [ebb_pkg::ADDR_W-1:0]    white_raddr;
    logic                          mark_re;
    logic [ebb_pkg::ADDR_W-1:0]    mark_raddr;
    logic [ebb_pkg::PIX_W-1:0]     white_q;
    logic [ebb_pkg::PIX_W-1:0]     mark_q;
    ebb_pkg::ebb_mem_req_t         req;
    ebb_pkg::ebb_eng_stat_t        stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd128;
            height_reg <= 6'd32;
            invert_reg <= 1'b0;
            sweep_reg  <= 4'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ebb_pkg::CFG_WIDTH:  width_reg  <= cfg_data[10:0];
                ebb_pkg::CFG_HEIGHT: height_reg <= cfg_data[5:0];
                ebb_pkg::CFG_INVERT: invert_reg <= cfg_data[0];
                ebb_pkg::CFG_SWEEP:  sweep_reg  <= cfg_data[3:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.image_width   = width_reg;
        cfg.image_height  = height_reg;
        cfg.invert_pixels = invert_reg;
        cfg.sweep_enable  = sweep_reg;
    end

    assign used_w    = ebb_pkg::used_width(width_reg);
    assign hmask     = ebb_pkg::height_mask(height_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign pend_move = pend_valid_reg && out_free;
    assign in_ready  = stat.idle && (!pend_valid_reg || out_free);
    assign accept    = in_valid && in_ready;
    assign act_load  = (in_word.action == ebb_pkg::ACT_LOAD);
    assign act_read  = (in_word.action == ebb_pkg::ACT_READ);
    assign act_run   = (in_word.action == ebb_pkg::ACT_RUN);
    assign in_range  = (ebb_pkg::CNT_W'(in_word.column_index) < used_w);
    assign idx_addr  = ebb_pkg::ADDR_W'(in_word.column_index);
    assign load_data = (invert_reg ? ~in_word.column_pixels : in_word.column_pixels)
                       & hmask;

    assign white_we    = accept && act_load && in_range;
    assign white_re    = req.white_re || (accept && act_read);
    assign white_raddr = (accept && act_read) ? idx_addr : req.white_raddr;
    assign mark_re     = req.mark_re || (accept && act_read);
    assign mark_raddr  = (accept && act_read) ? idx_addr : req.mark_raddr;

    ebb_ram #(
        .WIDTH (ebb_pkg::PIX_W),
        .DEPTH (ebb_pkg::MAX_COLUMNS)
    ) u_white_ram (
        .clk   (clk),
        .we    (white_we),
        .waddr (idx_addr),
        .wdata (load_data),
        .re    (white_re),
        .raddr (white_raddr),
        .rdata (white_q)
    );

    ebb_ram #(
        .WIDTH (ebb_pkg::PIX_W),
        .DEPTH (ebb_pkg::MAX_COLUMNS)
    ) u_mark_ram (
        .clk   (clk),
        .we    (req.mark_we),
        .waddr (req.mark_waddr),
        .wdata (req.mark_wdata),
        .re    (mark_re),
        .raddr (mark_raddr),
        .rdata (mark_q)
    );

    ebb_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && act_run),
        .cfg     (cfg),
        .white_q (white_q),
        .mark_q  (mark_q),
        .req     (req),
        .stat    (stat)
    );

    always_comb
    begin
        pend_valid_next  = pend_valid_reg;
        pend_read_next   = pend_read_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg;
        out_word_next    = out_word_reg;

        if (pend_move)
        begin
            pend_valid_next          = 1'b0;
            out_valid_next           = 1'b1;
            out_word_next.lit_pixels = pend_read_reg ? (white_q & ~mark_q & hmask) : '0;
            out_word_next.status     = pend_status_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept && !act_run)
        begin
            pend_valid_next  = 1'b1;
            pend_read_next   = act_read && in_range;
            pend_status_next = (act_load || act_read) && !in_range;
        end
        else if (stat.done)
        begin
            pend_valid_next  = 1'b1;
            pend_read_next   = 1'b0;
            pend_status_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_read_reg   <= pend_read_next;
        pend_status_reg <= pend_status_next;
        out_word_reg    <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ----- hw/rtl/ebb_checker.sv -----
// ----------------------------------------------------------------------------
// Edge background blanking checker
// Port-level checks on stalled result stability, word counts and run hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input ebb_pkg::ebb_in_t  in_word,
    input logic              out_valid,
    input logic              out_ready,
    input ebb_pkg::ebb_out_t out_word
);

    logic [2:0] outstanding_reg, outstanding_next;

    always_comb
    begin
        outstanding_next = outstanding_reg + 3'((in_valid && in_ready) ? 1 : 0)
                           - 3'((out_valid && out_ready) ? 1 : 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("stalled result word changed");

    a_run_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_word.action == ebb_pkg::ACT_RUN) |=> !in_ready)
        else $error("input accepted while a run is starting");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outstanding_reg != 3'd0))
        else $error("result word without an accepted input word");

    a_bounded_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 3'd2)
        else $error("more words in flight than the block can hold");

endmodule

bind edge_background_blanking_core ebb_checker u_ebb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);
